>>> rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam logic [2:0] FUNC_LIST      = 3'd0;
  localparam logic [2:0] FUNC_INS_BACK  = 3'd1;
  localparam logic [2:0] FUNC_DEL_BACK  = 3'd2;
  localparam logic [2:0] FUNC_INS_FRONT = 3'd3;
  localparam logic [2:0] FUNC_DEL_FRONT = 3'd4;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_LISTED    = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_DEL_EMPTY = 3'd4;

  typedef enum logic [2:0] {
    OP_LIST,
    OP_INS_BACK,
    OP_DEL_BACK,
    OP_INS_FRONT,
    OP_DEL_FRONT
  } op_e;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } cmd_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] item;
    logic               last;
  } res_t;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

>>> rtl/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/deq_front.sv
`timescale 1ns / 1ps

module deq_front import deq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  cmd_in_t   cmd_i,
  output logic      busy_o,
  output cmd_chan_t chan_o,
  input  logic      pop_i
);

  cmd_t       fifo_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       known;
  logic       push;
  logic       pop;
  cmd_t       cls;

  always_comb begin
    known     = 1'b1;
    cls.value = cmd_i.value;
    cls.op    = OP_LIST;
    case (cmd_i.func)
      FUNC_LIST:      cls.op = OP_LIST;
      FUNC_INS_BACK:  cls.op = OP_INS_BACK;
      FUNC_DEL_BACK:  cls.op = OP_DEL_BACK;
      FUNC_INS_FRONT: cls.op = OP_INS_FRONT;
      FUNC_DEL_FRONT: cls.op = OP_DEL_FRONT;
      default:        known  = 1'b0;
    endcase
  end

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o && known;
  assign pop    = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wptr_d = push ? !wptr_q : wptr_q;
    rptr_d = pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cls;
    end
  end

  assign chan_o.valid = (cnt_q != 2'd0);
  assign chan_o.cmd   = fifo_q[rptr_q];

endmodule

>>> rtl/deq_back.sv
`timescale 1ns / 1ps

module deq_back import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_chan_t chan_i,
  output logic      pop_o,
  output logic      result_valid_o,
  output res_t      result_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW:0]   DepthS = (IdxW + 1)'(DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  localparam logic StIdle = 1'b0;
  localparam logic StList = 1'b1;

  logic            state_q, state_d;
  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;
  logic            lst_q, lst_d;
  logic            lst_last_q, lst_last_d;

  logic            we;
  logic [IdxW-1:0] waddr;
  logic [IdxW-1:0] raddr;
  logic [31:0]     rdata;
  logic            full;
  logic            empty;
  logic            pos_last;

  function automatic logic [IdxW-1:0] wrap_add(logic [IdxW-1:0] a, logic [IdxW-1:0] b);
    logic [IdxW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= DepthS) begin
      sum = sum - DepthS;
    end
    return sum[IdxW-1:0];
  endfunction

  assign full     = (count_q == DepthC);
  assign empty    = (count_q == '0);
  assign raddr    = wrap_add(front_q, pos_q);
  assign pos_last = (CntW'({1'b0, pos_q}) + CntW'(1) == count_q);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    pos_d       = pos_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;
    lst_d       = 1'b0;
    lst_last_d  = 1'b0;
    we          = 1'b0;
    waddr       = wrap_add(front_q, count_q[IdxW-1:0]);
    pop_o       = 1'b0;
    case (state_q)
      StIdle: begin
        if (chan_i.valid) begin
          pop_o = 1'b1;
          case (chan_i.cmd.op)
            OP_LIST: begin
              if (empty) begin
                res_valid_d  = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                lst_d      = 1'b1;
                lst_last_d = pos_last;
                if (!pos_last) begin
                  pos_d   = pos_q + IdxW'(1);
                  state_d = StList;
                end
              end
            end
            OP_INS_BACK, OP_INS_FRONT: begin
              res_valid_d = 1'b1;
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                res_d.status = ST_DONE;
                we           = 1'b1;
                count_d      = count_q + CntW'(1);
                if (chan_i.cmd.op == OP_INS_FRONT) begin
                  front_d = (front_q == '0) ? LastIdx : front_q - IdxW'(1);
                  waddr   = front_d;
                end
              end
            end
            OP_DEL_BACK, OP_DEL_FRONT: begin
              res_valid_d = 1'b1;
              if (empty) begin
                res_d.status = ST_DEL_EMPTY;
              end else begin
                res_d.status = ST_DONE;
                count_d      = count_q - CntW'(1);
                if (chan_i.cmd.op == OP_DEL_FRONT) begin
                  front_d = (front_q == LastIdx) ? '0 : front_q + IdxW'(1);
                end
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      StList: begin
        lst_d      = 1'b1;
        lst_last_d = pos_last;
        if (pos_last) begin
          pos_d   = '0;
          state_d = StIdle;
        end else begin
          pos_d = pos_q + IdxW'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      front_q     <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      res_valid_q <= 1'b0;
      lst_q       <= 1'b0;
      lst_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      res_valid_q <= res_valid_d;
      lst_q       <= lst_d;
      lst_last_q  <= lst_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  deq_ram #(
    .Width (32),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (chan_i.cmd.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    result_valid_o = res_valid_q || lst_q;
    result_o       = res_q;
    if (lst_q) begin
      result_o.status = ST_LISTED;
      result_o.item   = rdata;
      result_o.last   = lst_last_q;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_valid_q && lst_q))
    else $error("status and list transfer collide");

  a_list_holds_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StList |-> !pop_o && $stable(count_q) && $stable(front_q))
    else $error("store changed during list");

  a_list_ends_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> pos_q == '0)
    else $error("list position not cleared");

endmodule

>>> rtl/double_ended_queue_unit.sv
// status: the command queue registers a start, then the result register strobes its status
// list: count transfers (or one empty marker), one per cycle, the first timed as a status transfer
// throughput: one insert or delete per cycle while no list streams; a list holds the store port to its end
// a two-entry command queue absorbs starts while a list streams; busy_o rises when it is full
// rst_ni is asynchronous: pointers, count and queue clear; store contents are undefined
`timescale 1ns / 1ps

module double_ended_queue_unit import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  cmd_in_t cmd_i,
  output logic    busy_o,
  output logic    result_valid_o,
  output res_t    result_o
);

  cmd_chan_t chan;
  logic      pop;

  deq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .busy_o  (busy_o),
    .chan_o  (chan),
    .pop_i   (pop)
  );

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .chan_i         (chan),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
